// ===== rtl/core/ctcp_pkg.sv =====
// Shared types, constants and byte-map tables for the code point decoder.
// No dependencies; imported by ctcp_decode_step and the top level.
package ctcp_pkg;

    localparam logic [1:0] ENC_UTF8   = 2'd0;
    localparam logic [1:0] ENC_LATIN1 = 2'd1;
    localparam logic [1:0] ENC_LATIN9 = 2'd2;
    localparam logic [1:0] ENC_CP1252 = 2'd3;

    localparam int          CP_W      = 21;
    localparam logic [20:0] CP_REPL   = 21'h00FFFD;
    localparam logic [20:0] CP_MAX    = 21'h10FFFF;

    typedef logic [CP_W-1:0] t_cp;

    // UTF-8 sequence state carried between bytes
    typedef struct packed {
        logic [1:0] pending_count;
        t_cp        accum_value;
        logic [1:0] sequence_length;
        logic       skipping;
    } t_utf8_state;

    // result of one byte
    typedef struct packed {
        logic emit;
        t_cp  code_point;
        logic replaced;
    } t_step_result;

    function automatic t_cp map_latin9(input logic [7:0] b);
        case (b)
            8'hA4:   map_latin9 = 21'h0020AC;
            8'hA6:   map_latin9 = 21'h000160;
            8'hA8:   map_latin9 = 21'h000161;
            8'hB4:   map_latin9 = 21'h00017D;
            8'hB8:   map_latin9 = 21'h00017E;
            8'hBC:   map_latin9 = 21'h000152;
            8'hBD:   map_latin9 = 21'h000153;
            8'hBE:   map_latin9 = 21'h000178;
            default: map_latin9 = {13'd0, b};
        endcase
    endfunction

    // bytes 80-9F of Windows-1252, indexed by the low five bits
    function automatic logic [15:0] cp1252_high(input logic [4:0] idx);
        case (idx)
            5'd0:    cp1252_high = 16'h20AC;
            5'd1:    cp1252_high = 16'h0081;
            5'd2:    cp1252_high = 16'h201A;
            5'd3:    cp1252_high = 16'h0192;
            5'd4:    cp1252_high = 16'h201E;
            5'd5:    cp1252_high = 16'h2026;
            5'd6:    cp1252_high = 16'h2020;
            5'd7:    cp1252_high = 16'h2021;
            5'd8:    cp1252_high = 16'h02C6;
            5'd9:    cp1252_high = 16'h2030;
            5'd10:   cp1252_high = 16'h0160;
            5'd11:   cp1252_high = 16'h2039;
            5'd12:   cp1252_high = 16'h0152;
            5'd13:   cp1252_high = 16'h008D;
            5'd14:   cp1252_high = 16'h017D;
            5'd15:   cp1252_high = 16'h008F;
            5'd16:   cp1252_high = 16'h0090;
            5'd17:   cp1252_high = 16'h2018;
            5'd18:   cp1252_high = 16'h2019;
            5'd19:   cp1252_high = 16'h201C;
            5'd20:   cp1252_high = 16'h201D;
            5'd21:   cp1252_high = 16'h2022;
            5'd22:   cp1252_high = 16'h2013;
            5'd23:   cp1252_high = 16'h2014;
            5'd24:   cp1252_high = 16'h02DC;
            5'd25:   cp1252_high = 16'h2122;
            5'd26:   cp1252_high = 16'h0161;
            5'd27:   cp1252_high = 16'h203A;
            5'd28:   cp1252_high = 16'h0153;
            5'd29:   cp1252_high = 16'h009D;
            5'd30:   cp1252_high = 16'h017E;
            default: cp1252_high = 16'h0178;
        endcase
    endfunction

endpackage

// ===== rtl/core/charset_to_codepoint_decoder_core.sv =====
// Top level of the byte to Unicode code point decoder.
// Depends on ctcp_pkg and ctcp_decode_step.
//
// Takes one byte per transaction and delivers at most one code point per
// byte. Throughput is one byte per clock while the output is not stalled:
// a byte is held in an input register, decoded by one level of logic
// (ctcp_decode_step) against the UTF-8 sequence state, and the code point
// lands in an output register when the input register advances. A stalled
// output holds the input register and drops s_axis_tready. Bytes that only
// extend a UTF-8 sequence, or are dropped while realigning, give no output
// transaction. The user must write the encoding register (0 UTF-8,
// 1 ISO-8859-1, 2 ISO-8859-15, 3 Windows-1252) only while the block is
// idle; the block itself does not enforce it. A partial UTF-8 sequence
// survives a detour through a byte-map mode.
module charset_to_codepoint_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data,     // encoding
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic        m_axis_tuser    // [0] replaced
);
    import ctcp_pkg::*;

    logic [1:0]   r_encoding;
    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    t_utf8_state  r_state;
    t_utf8_state  n_state;
    t_step_result step_res;
    logic         r_out_valid;
    t_cp          r_out_cp;
    logic         r_out_repl;
    logic         advance;

    assign o_cfg_ready   = 1'b1;
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    ctcp_decode_step u_step (
        .i_encoding (r_encoding),
        .i_byte     (r_in_byte),
        .i_state    (r_state),
        .o_state    (n_state),
        .o_result   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_encoding  <= ENC_UTF8;
            r_in_valid  <= 1'b0;
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_encoding <= i_cfg_data;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= step_res.emit;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
        if (advance && step_res.emit) begin
            r_out_cp   <= step_res.code_point;
            r_out_repl <= step_res.replaced;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_out_cp};
    assign m_axis_tuser  = r_out_repl;

endmodule

// ===== rtl/core/ctcp_decode_step.sv =====
// Combinational decode of one byte: byte-map lookup or one UTF-8 step.
// Depends on ctcp_pkg for state/result types and the remap tables.
module ctcp_decode_step (
    input  logic [1:0]           i_encoding,
    input  logic [7:0]           i_byte,
    input  ctcp_pkg::t_utf8_state i_state,
    output ctcp_pkg::t_utf8_state o_state,
    output ctcp_pkg::t_step_result o_result
);
    import ctcp_pkg::*;

    function automatic logic value_is_bad(input t_cp v, input logic [1:0] len);
        logic [20:0] min_v;
        case (len)
            2'd1:    min_v = 21'h000080;
            2'd2:    min_v = 21'h000800;
            2'd3:    min_v = 21'h010000;
            default: min_v = 21'h000000;
        endcase
        value_is_bad = (v < min_v) || (v > CP_MAX) ||
                       (v inside {[21'h00D800:21'h00DFFF]}) ||
                       (v inside {[21'h00FDD0:21'h00FDEF]}) ||
                       (v[15:1] == 15'h7FFF);
    endfunction

    logic        cont;
    t_cp         accum_shift;
    logic [1:0]  pending_dec;

    assign cont        = (i_byte[7:6] == 2'b10);
    assign accum_shift = {i_state.accum_value[14:0], i_byte[5:0]};
    assign pending_dec = i_state.pending_count - 2'd1;

    always_comb begin
        logic go;
        go       = 1'b1;
        o_state  = i_state;
        o_result = '0;
        case (i_encoding)
            ENC_LATIN1: begin
                o_result.emit       = 1'b1;
                o_result.code_point = {13'd0, i_byte};
            end
            ENC_LATIN9: begin
                o_result.emit       = 1'b1;
                o_result.code_point = map_latin9(i_byte);
            end
            ENC_CP1252: begin
                o_result.emit = 1'b1;
                if (i_byte inside {[8'h80:8'h9F]}) begin
                    o_result.code_point = {5'd0, cp1252_high(i_byte[4:0])};
                end else begin
                    o_result.code_point = {13'd0, i_byte};
                end
            end
            default: begin
                // realigning after an error: drop continuation bytes and F8-FF
                if (i_state.skipping) begin
                    if (cont || i_byte >= 8'hF8) begin
                        go = 1'b0;
                    end else begin
                        o_state.skipping = 1'b0;
                    end
                end
                if (go) begin
                    if (i_state.pending_count != 2'd0) begin
                        if (!cont) begin
                            // breaking byte is consumed
                            o_state.pending_count = 2'd0;
                            o_state.skipping      = 1'b1;
                            o_result.emit         = 1'b1;
                            o_result.code_point   = CP_REPL;
                            o_result.replaced     = 1'b1;
                        end else begin
                            o_state.accum_value   = accum_shift;
                            o_state.pending_count = pending_dec;
                            if (pending_dec == 2'd0) begin
                                o_result.emit = 1'b1;
                                if (value_is_bad(accum_shift, i_state.sequence_length)) begin
                                    o_result.code_point = CP_REPL;
                                    o_result.replaced   = 1'b1;
                                end else begin
                                    o_result.code_point = accum_shift;
                                end
                            end
                        end
                    end else if (!i_byte[7]) begin
                        o_result.emit       = 1'b1;
                        o_result.code_point = {13'd0, i_byte};
                    end else if (i_byte[7:5] == 3'b110) begin
                        o_state.accum_value     = {16'd0, i_byte[4:0]};
                        o_state.pending_count   = 2'd1;
                        o_state.sequence_length = 2'd1;
                    end else if (i_byte[7:4] == 4'b1110) begin
                        o_state.accum_value     = {17'd0, i_byte[3:0]};
                        o_state.pending_count   = 2'd2;
                        o_state.sequence_length = 2'd2;
                    end else if (i_byte[7:3] == 5'b11110) begin
                        o_state.accum_value     = {18'd0, i_byte[2:0]};
                        o_state.pending_count   = 2'd3;
                        o_state.sequence_length = 2'd3;
                    end else begin
                        // stray continuation or F8-FF lead
                        o_state.skipping    = 1'b1;
                        o_result.emit       = 1'b1;
                        o_result.code_point = CP_REPL;
                        o_result.replaced   = 1'b1;
                    end
                end
            end
        endcase
    end

endmodule
